### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checkers of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### src/mtsd_pkg.sv
// ----------------------------------------------------------------------------
// mtsd_pkg
// Types, constants and codes shared by the seed derive and filter block.
// ----------------------------------------------------------------------------
package mtsd_pkg;

	// Generator constants.
	localparam logic [31:0] MT_MULT     = 32'h6c07_8965;
	localparam logic [31:0] MT_UPPER    = 32'h8000_0000;
	localparam logic [31:0] MT_LOWER    = 32'h7fff_ffff;
	localparam logic [31:0] MT_MATRIX   = 32'h9908_b0df;
	localparam logic [31:0] MT_TEMPER_B = 32'h9d2c_5680;
	localparam logic [31:0] MT_TEMPER_C = 32'hefc6_0000;

	// Initialization steps up to the element that twists into output two.
	localparam int unsigned INIT_STEPS = 398;

	// Filter table size, fixed by the width of the entry index.
	localparam int unsigned FILTER_DEPTH = 16;
	localparam int unsigned FILTER_IDX_W = $clog2(FILTER_DEPTH);

	// Operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST  = 1'b1;

	// Filter modes.
	localparam logic [2:0] MODE_NONE      = 3'd0;
	localparam logic [2:0] MODE_ID1       = 3'd1;
	localparam logic [2:0] MODE_ID2       = 3'd2;
	localparam logic [2:0] MODE_ID_PAIR   = 3'd3;
	localparam logic [2:0] MODE_SHINY     = 3'd4;
	localparam logic [2:0] MODE_ID1_SHINY = 3'd5;
	localparam logic [2:0] MODE_SHINY_ALT = 3'd6;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_COUNT = 2'd1;

	typedef struct packed {
		logic        op;
		logic [31:0] seed;
		logic [31:0] delay_tag;
		logic [5:0]  seconds_tag;
		logic [3:0]  entry_index;
		logic [15:0] entry_first;
		logic [15:0] entry_second;
	} in_word_t;

	typedef struct packed {
		logic [31:0] seed_out;
		logic [31:0] delay_out;
		logic [15:0] first_id;
		logic [15:0] second_id;
		logic [12:0] shiny_value;
		logic [5:0]  seconds_out;
	} out_word_t;

	// Payload handed from cell to cell. For a table write, seed carries the
	// entry value and the low bits of delay carry the entry index.
	typedef struct packed {
		logic        op;
		logic [31:0] x;
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] seed;
		logic [31:0] delay;
		logic [5:0]  secs;
	} chain_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] count;
	} filter_cfg_t;

	typedef struct packed {
		logic                    en;
		logic [FILTER_IDX_W-1:0] index;
		logic [31:0]             value;
	} table_wr_t;

endpackage

### src/mt_seed_id_derive_and_filter.sv
// ----------------------------------------------------------------------------
// mt_seed_id_derive_and_filter
// Derives the two ids and the shiny value of a seed and filters on them.
// ----------------------------------------------------------------------------
// Usage: the host sends words on the seed channel (seed_valid, seed_stall,
// seed_word). A word with op set tests seed_word.seed; a word with op clear
// loads filter table slot entry_index with entry_first and entry_second.
// Matching seeds leave as words on the result channel (result_valid,
// result_stall, result_word); a seed that fails the filter, and every table
// load, produces no word. The config channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) sets filter_mode and filter_count and should be used
// only while no work is in flight.
// Throughput is one word per cycle while result_stall does not hold the row.
// A word passes 398 cells of the initialization recurrence, each with
// one 32-bit multiplier, one twist and temper stage, and the result register.
// Table loads travel the same row, so they take effect in order with tests.
// Reset clears the pipeline valid bits, the result valid bit and the config
// registers; the filter table holds no defined value until loaded.
// When the receiver stalls a held result word, the whole row freezes and
// seed_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module mt_seed_id_derive_and_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  seed_valid,
	output logic                                  seed_stall,
	input  mtsd_pkg::in_word_t                    seed_word,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output mtsd_pkg::out_word_t                   result_word,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mtsd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [4:0]                            cfg_data
);
	import mtsd_pkg::*;

	// The row advances only when the result register is free or draining.
	logic advance;

	// Configuration registers.
	filter_cfg_t cfg_q;

	// Cell row; element zero is the entry point.
	logic   chain_valid [INIT_STEPS+1];
	chain_t chain_data  [INIT_STEPS+1];

	// Twist and temper stage.
	logic        temper_valid_s1;
	logic        temper_op_s1;
	logic [31:0] temper_seed_s1;
	logic [31:0] temper_delay_s1;
	logic [5:0]  temper_secs_s1;
	logic [15:0] temper_id1_s1;
	logic [15:0] temper_id2_s1;
	logic [12:0] temper_shiny_s1;

	logic [31:0] mix;
	logic [31:0] twist;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] t3;
	logic [31:0] t4;

	table_wr_t wr;
	logic      match;

	logic      result_valid_q;
	out_word_t result_q;

	assign advance    = !result_valid_q || !result_stall;
	assign seed_stall = !advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FILTER_MODE:  cfg_q.mode  <= cfg_data[2:0];
				CFG_FILTER_COUNT: cfg_q.count <= cfg_data;
				default:          cfg_q       <= cfg_q;
			endcase
		end
	end

	// A table load reuses the seed and delay slots for its entry and index.
	always_comb begin
		chain_valid[0]      = seed_valid;
		chain_data[0].op    = seed_word.op;
		chain_data[0].x     = seed_word.seed;
		chain_data[0].s1    = '0;
		chain_data[0].s2    = '0;
		chain_data[0].secs  = seed_word.seconds_tag;
		if (seed_word.op == OP_WRITE) begin
			chain_data[0].seed  = {seed_word.entry_second, seed_word.entry_first};
			chain_data[0].delay = {28'd0, seed_word.entry_index};
		end else begin
			chain_data[0].seed  = seed_word.seed;
			chain_data[0].delay = seed_word.delay_tag;
		end
	end

	for (genvar g = 0; g < INIT_STEPS; g++) begin : g_cell
		mtsd_cell #(
			.STEP(g + 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.in_valid (chain_valid[g]),
			.in_data  (chain_data[g]),
			.valid_s1 (chain_valid[g+1]),
			.data_s1  (chain_data[g+1])
		);
	end

	// Twist elements one and two against the last element, then temper.
	always_comb begin
		mix   = (chain_data[INIT_STEPS].s1 & MT_UPPER) | (chain_data[INIT_STEPS].s2 & MT_LOWER);
		twist = (mix >> 1) ^ (mix[0] ? MT_MATRIX : 32'd0) ^ chain_data[INIT_STEPS].x;
		t1    = twist ^ (twist >> 11);
		t2    = t1 ^ ((t1 << 7) & MT_TEMPER_B);
		t3    = t2 ^ ((t2 << 15) & MT_TEMPER_C);
		t4    = t3 ^ (t3 >> 18);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temper_valid_s1 <= 1'b0;
		end else if (advance) begin
			temper_valid_s1 <= chain_valid[INIT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			temper_op_s1    <= chain_data[INIT_STEPS].op;
			temper_seed_s1  <= chain_data[INIT_STEPS].seed;
			temper_delay_s1 <= chain_data[INIT_STEPS].delay;
			temper_secs_s1  <= chain_data[INIT_STEPS].secs;
			temper_id1_s1   <= t4[15:0];
			temper_id2_s1   <= t4[31:16];
			temper_shiny_s1 <= 13'((t4[15:0] ^ t4[31:16]) >> 3);
		end
	end

	// Table loads land here, in order with the tests around them.
	always_comb begin
		wr.en    = advance && temper_valid_s1 && (temper_op_s1 == OP_WRITE);
		wr.index = temper_delay_s1[FILTER_IDX_W-1:0];
		wr.value = temper_seed_s1;
	end

	mtsd_filter u_filter (
		.clk   (clk),
		.cfg   (cfg_q),
		.wr    (wr),
		.id1   (temper_id1_s1),
		.id2   (temper_id2_s1),
		.shiny (temper_shiny_s1),
		.match (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= temper_valid_s1 && (temper_op_s1 == OP_TEST) && match;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.seed_out    <= temper_seed_s1;
			result_q.delay_out   <= temper_delay_s1;
			result_q.first_id    <= temper_id1_s1;
			result_q.second_id   <= temper_id2_s1;
			result_q.shiny_value <= temper_shiny_s1;
			result_q.seconds_out <= temper_secs_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_q;

endmodule

### src/mtsd_cell.sv
// ----------------------------------------------------------------------------
// mtsd_cell
// One step of the generator initialization recurrence, registered.
// ----------------------------------------------------------------------------
module mtsd_cell #(
	parameter int unsigned STEP = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  mtsd_pkg::chain_t in_data,
	output logic            valid_s1,
	output mtsd_pkg::chain_t data_s1
);
	import mtsd_pkg::*;

	logic [31:0] mixed;
	logic [31:0] prod;
	logic [31:0] next_x;
	chain_t      next_data;

	// The first two elements are kept for the twist at the end of the row.
	always_comb begin
		mixed     = in_data.x ^ (in_data.x >> 30);
		prod      = MT_MULT * mixed;
		next_x    = prod + 32'(STEP);
		next_data = in_data;
		next_data.x = next_x;
		if (STEP == 1) begin
			next_data.s1 = next_x;
		end
		if (STEP == 2) begin
			next_data.s2 = next_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= next_data;
		end
	end

endmodule

### src/mtsd_filter.sv
// ----------------------------------------------------------------------------
// mtsd_filter
// Filter table and the parallel compare of one seed's ids against it.
// ----------------------------------------------------------------------------
module mtsd_filter (
	input  logic                  clk,
	input  mtsd_pkg::filter_cfg_t cfg,
	input  mtsd_pkg::table_wr_t   wr,
	input  logic [15:0]           id1,
	input  logic [15:0]           id2,
	input  logic [12:0]           shiny,
	output logic                  match
);
	import mtsd_pkg::*;

	localparam logic [4:0] DEPTH_CNT = 5'(FILTER_DEPTH);

	logic [31:0] table_q [FILTER_DEPTH];
	logic [4:0]  count_eff;
	logic        hit;
	logic [15:0] a;
	logic [15:0] b;
	logic [15:0] shiny_w;

	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.index) < FILTER_DEPTH)) begin
			table_q[wr.index] <= wr.value;
		end
	end

	always_comb begin
		count_eff = (cfg.count > DEPTH_CNT) ? DEPTH_CNT : cfg.count;
		shiny_w   = {3'b000, shiny};
		hit       = 1'b0;
		a         = '0;
		b         = '0;
		for (int k = 0; k < FILTER_DEPTH; k++) begin
			a = table_q[k][15:0];
			b = table_q[k][31:16];
			if (5'(k) < count_eff) begin
				case (cfg.mode) inside
					MODE_ID1:                  hit = hit | (id1 == a);
					MODE_ID2:                  hit = hit | (id2 == a);
					MODE_ID_PAIR:              hit = hit | ((id1 == a) && (id2 == b));
					MODE_SHINY, MODE_SHINY_ALT: hit = hit | (shiny_w == a);
					MODE_ID1_SHINY:            hit = hit | ((id1 == a) && (shiny_w == b));
					default:                   hit = hit;
				endcase
			end
		end
		match = (cfg.mode == MODE_NONE) ? 1'b1 : hit;
	end

endmodule

### src/mtsd_checker.sv
// ----------------------------------------------------------------------------
// mtsd_checker
// Port-level checks for the seed derive and filter block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtsd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                seed_stall,
	input logic                result_valid,
	input logic                result_stall,
	input mtsd_pkg::out_word_t result_word
);
	import mtsd_pkg::*;

	// Input backpressure only ever comes from a held, stalled result word.
	`CHK_IMPLY(a_stall_source, clk, arst_n, seed_stall, result_valid && result_stall)

	// A result word only appears right after the row has moved.
	`CHK_IMPLY(a_rise_after_move, clk, arst_n, $rose(result_valid), !$past(seed_stall))

	// The shiny value always agrees with the two ids beside it.
	`CHK_IMPLY(a_shiny_consistent, clk, arst_n, result_valid,
		result_word.shiny_value == 13'((result_word.first_id ^ result_word.second_id) >> 3))

	// A stalled result word stays put.
	`CHK_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result_word))

endmodule

bind mt_seed_id_derive_and_filter mtsd_checker u_mtsd_checker (.*);

### bench/tb_mt_seed_id_derive_and_filter.sv
// ----------------------------------------------------------------------------
// tb_mt_seed_id_derive_and_filter
// Self-checking bench for the seed id derive and filter block. Table loads
// and seed tests stream in on the seed channel. A local model of the
// generator and the filter predicts which seeds must come out and with which
// ids. Both channels idle at random, and the filter mode and count are
// changed between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_mt_seed_id_derive_and_filter;
	import mtsd_pkg::*;

	// Mode code seven carries no meaning, so no seed may pass under it.
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	// Register indexes that select no register.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
	// Outlasts the cell row, the twist and temper stage and the result register.
	localparam int unsigned SETTLE_CYCLES = 420;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned PHASE_WORDS   = 38;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic seed_valid = 1'b0;
	logic seed_stall;
	in_word_t seed_word = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_word_t result_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	mt_seed_id_derive_and_filter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_valid  (seed_valid),
		.seed_stall  (seed_stall),
		.seed_word   (seed_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_word (result_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Words waiting to be sent, and the matches that the model says are owed.
	in_word_t  words_to_send[$];
	out_word_t matches_due[$];

	// Appends to the tail of the two queues above.
	function automatic void queue_word(input in_word_t w);
		words_to_send = {words_to_send, w};
	endfunction

	function automatic void owe_match(input out_word_t m);
		matches_due = {matches_due, m};
	endfunction

	// The bench's own copy of the filter state, updated in acceptance order.
	logic [31:0] filter_copy[FILTER_DEPTH];
	logic [2:0]  mode_now = MODE_NONE;
	logic [4:0]  count_now = '0;

	// Seeds whose ids were last loaded into each slot; used to aim tests at
	// seeds that should hit the filter.
	logic [31:0] slot_seed[FILTER_DEPTH];

	bit bursts_on = 1'b1;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int mismatch_count = 0;
	int unsigned results_seen = 0;
	int unsigned tests_sent = 0;
	int unsigned loads_sent = 0;
	int unsigned settings_used = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Second output of MT19937: run the init recurrence to element 398, twist
	// element 1 against elements 2 and 398, then temper.
	function automatic logic [31:0] mt_second_draw(input logic [31:0] s);
		logic [31:0] x;
		logic [31:0] e1;
		logic [31:0] e2;
		logic [31:0] v;
		int unsigned i;
		x = s;
		e1 = '0;
		e2 = '0;
		for (i = 1; i <= INIT_STEPS; i++) begin
			x = MT_MULT * (x ^ (x >> 30)) + i;
			if (i == 1)
				e1 = x;
			if (i == 2)
				e2 = x;
		end
		v = (e1 & MT_UPPER) | (e2 & MT_LOWER);
		v = (v >> 1) ^ (v[0] ? MT_MATRIX : 32'h0) ^ x;
		v = v ^ (v >> 11);
		v = v ^ ((v << 7) & MT_TEMPER_B);
		v = v ^ ((v << 15) & MT_TEMPER_C);
		v = v ^ (v >> 18);
		return v;
	endfunction

	// Filter decision under the current mode and count. The count saturates
	// at the table depth; mode none passes everything.
	function automatic bit filter_hit(input logic [15:0] id_lo, input logic [15:0] id_hi,
			input logic [12:0] shiny);
		int unsigned n;
		int unsigned k;
		logic [15:0] a;
		logic [15:0] b;
		bit hit;
		n = (count_now > FILTER_DEPTH) ? FILTER_DEPTH : count_now;
		if (mode_now == MODE_NONE)
			return 1'b1;
		hit = 1'b0;
		for (k = 0; k < n; k++) begin
			a = filter_copy[k][15:0];
			b = filter_copy[k][31:16];
			case (mode_now) inside
				MODE_ID1:                  if (id_lo == a) hit = 1'b1;
				MODE_ID2:                  if (id_hi == a) hit = 1'b1;
				MODE_ID_PAIR:              if (id_lo == a && id_hi == b) hit = 1'b1;
				MODE_SHINY, MODE_SHINY_ALT: if ({3'b000, shiny} == a) hit = 1'b1;
				MODE_ID1_SHINY:            if (id_lo == a && {3'b000, shiny} == b) hit = 1'b1;
				default:                   hit = 1'b0;
			endcase
		end
		return hit;
	endfunction

	// Applies one accepted word to the local copy and queues the match it owes.
	task automatic predict_word(input in_word_t w);
		logic [31:0] draw;
		out_word_t m;
		if (w.op == OP_WRITE) begin
			filter_copy[w.entry_index] = {w.entry_second, w.entry_first};
			loads_sent++;
		end else begin
			tests_sent++;
			draw = mt_second_draw(w.seed);
			m.seed_out    = w.seed;
			m.delay_out   = w.delay_tag;
			m.first_id    = draw[15:0];
			m.second_id   = draw[31:16];
			m.shiny_value = draw[15:3] ^ draw[31:19];
			m.seconds_out = w.seconds_tag;
			if (filter_hit(m.first_id, m.second_id, m.shiny_value))
				owe_match(m);
		end
	endtask

	function automatic in_word_t random_word();
		in_word_t w;
		w.op           = 1'($urandom_range(0, 1));
		w.seed         = $urandom;
		w.delay_tag    = $urandom;
		w.seconds_tag  = 6'($urandom_range(0, 63));
		w.entry_index  = 4'($urandom_range(0, 15));
		w.entry_first  = 16'($urandom);
		w.entry_second = 16'($urandom);
		return w;
	endfunction

	function automatic in_word_t test_word(input logic [31:0] s);
		in_word_t w;
		w = random_word();
		w.op = OP_TEST;
		w.seed = s;
		return w;
	endfunction

	// Table load laid out so that seed s hits slot k under the given mode. A
	// broken load spoils one half, which gives near misses in the pair modes.
	function automatic in_word_t load_word(input int unsigned k, input logic [31:0] s,
			input logic [2:0] mode, input bit broken);
		in_word_t w;
		logic [31:0] draw;
		logic [15:0] shiny16;
		w = random_word();
		w.op = OP_WRITE;
		w.entry_index = 4'(k);
		draw = mt_second_draw(s);
		shiny16 = {3'b000, draw[15:3] ^ draw[31:19]};
		case (mode) inside
			MODE_ID1:                  w.entry_first = draw[15:0];
			MODE_ID2:                  w.entry_first = draw[31:16];
			MODE_ID_PAIR: begin
				w.entry_first  = draw[15:0];
				w.entry_second = draw[31:16];
			end
			MODE_SHINY, MODE_SHINY_ALT: w.entry_first = shiny16;
			MODE_ID1_SHINY: begin
				w.entry_first  = draw[15:0];
				w.entry_second = shiny16;
			end
			default: ;
		endcase
		if (broken) begin
			if ($urandom_range(0, 1) == 0)
				w.entry_first = w.entry_first ^ 16'($urandom_range(1, 65535));
			else
				w.entry_second = w.entry_second ^ 16'($urandom_range(1, 65535));
		end
		return w;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Sender. The word on the channel is retired when valid is high and stall
	// is low at the edge; the model sees it at that same edge, so its table
	// copy follows the block's order of loads and tests.
	always @(posedge clk) begin
		if (arst_n) begin
			if (seed_valid && !seed_stall)
				predict_word(seed_word);
			if (!seed_valid || !seed_stall) begin
				if (send_gap != 0) begin
					seed_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (words_to_send.size() != 0) begin
					seed_word <= words_to_send.pop_front();
					seed_valid <= 1'b1;
					if (bursts_on && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 9);
				end else begin
					seed_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Every retired result is checked against the oldest owed match,
	// and the stall line is raised in random bursts.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (matches_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time,
						result_word);
					mismatch_count++;
				end else begin
					want = matches_due.pop_front();
					check_field("seed_out", want.seed_out, result_word.seed_out);
					check_field("delay_out", want.delay_out, result_word.delay_out);
					check_field("first_id", 32'(want.first_id), 32'(result_word.first_id));
					check_field("second_id", 32'(want.second_id),
						32'(result_word.second_id));
					check_field("shiny_value", 32'(want.shiny_value),
						32'(result_word.shiny_value));
					check_field("seconds_out", 32'(want.seconds_out),
						32'(result_word.seconds_out));
				end
			end
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				result_stall <= 1'b0;
				if (bursts_on && $urandom_range(0, 11) == 0)
					stall_left <= $urandom_range(1, 9);
			end
		end
	end

	// Waits until the sender is empty and every owed match has come, then lets
	// the row run dry, since loads and misses leave no trace at the output.
	task automatic settle();
		int unsigned quiet;
		int unsigned last_seen;
		while (words_to_send.size() != 0 || seed_valid)
			@(negedge clk);
		quiet = 0;
		last_seen = results_seen;
		while (matches_due.size() != 0 && quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if (results_seen != last_seen) begin
				last_seen = results_seen;
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		if (matches_due.size() != 0) begin
			$display("%0t: %0d results missing, expected seed %h, got nothing", $time,
				matches_due.size(), matches_due[0].seed_out);
			mismatch_count += matches_due.size();
			matches_due.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [4:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FILTER_MODE)
			mode_now = data[2:0];
		else if (idx == CFG_FILTER_COUNT)
			count_now = data;
	endtask

	// One filter setting: program it, aim the first slots at fresh seeds, then
	// mix hits, random seeds, reloads and spoiled reloads.
	task automatic run_phase(input logic [2:0] mode, input logic [4:0] count);
		int unsigned eff;
		int unsigned k;
		int unsigned r;
		int unsigned slot;
		settle();
		write_cfg(CFG_FILTER_MODE, {2'($urandom_range(0, 3)), mode});
		write_cfg(CFG_FILTER_COUNT, count);
		settings_used++;
		eff = (count > FILTER_DEPTH) ? FILTER_DEPTH : count;
		for (k = 0; k < eff; k++) begin
			slot_seed[k] = $urandom;
			queue_word(load_word(k, slot_seed[k], mode, 1'b0));
		end
		for (k = 0; k < PHASE_WORDS; k++) begin
			r = $urandom_range(0, 99);
			slot = (eff != 0 && r < 35) ? $urandom_range(0, eff - 1) : $urandom_range(0, 15);
			if (r < 45) begin
				queue_word(test_word(slot_seed[slot]));
			end else if (r < 75) begin
				queue_word(test_word($urandom));
			end else begin
				slot_seed[slot] = $urandom;
				queue_word(load_word(slot, slot_seed[slot], mode, r >= 90));
			end
		end
	endtask

	initial begin
		in_word_t w;
		int unsigned k;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset setting, mode none. Every slot is
		// loaded first so that no later compare can touch an unwritten entry.
		for (k = 0; k < FILTER_DEPTH - 2; k++) begin
			slot_seed[k] = (k == 0) ? 32'h0000_0000 :
				(k == 1) ? 32'hffff_ffff : (k == 2) ? 32'h8000_0000 : $urandom;
			queue_word(load_word(k, slot_seed[k], MODE_ID_PAIR, 1'b0));
		end
		// Field extremes in the table itself, with the unused fields pinned too.
		w = '0;
		w.op = OP_WRITE;
		w.entry_index = 4'd14;
		queue_word(w);
		w = '1;
		w.op = OP_WRITE;
		w.entry_index = 4'd15;
		queue_word(w);
		slot_seed[14] = $urandom;
		slot_seed[15] = $urandom;

		// Seeds at the ends of the range and tags at their extremes, including
		// seconds values 59, 60, 61 and 63.
		w = '0;
		w.op = OP_TEST;
		queue_word(w);
		w = '1;
		w.seconds_tag = 6'd60;
		queue_word(w);
		w = test_word(32'h0000_0001);
		w.delay_tag = '0;
		w.seconds_tag = 6'd63;
		queue_word(w);
		w = test_word(32'h8000_0000);
		w.seconds_tag = 6'd59;
		queue_word(w);
		w = test_word(32'h7fff_ffff);
		w.delay_tag = 32'h8000_0000;
		w.seconds_tag = 6'd61;
		queue_word(w);
		queue_word(test_word(32'd5489));
		queue_word(test_word(32'h1234_5678));
		queue_word(test_word($urandom));
		queue_word(test_word($urandom));
		settle();

		// Writes to indexes that select no register must change nothing.
		write_cfg(CFG_SPARE_LO, 5'($urandom));
		write_cfg(CFG_SPARE_HI, 5'($urandom));

		// Every mode, counts from zero through the depth and past it.
		run_phase(MODE_ID1, 5'd16);
		run_phase(MODE_ID2, 5'd1);
		run_phase(MODE_ID_PAIR, 5'd8);
		run_phase(MODE_SHINY, 5'd16);
		run_phase(MODE_ID1_SHINY, 5'd31);
		run_phase(MODE_SHINY_ALT, 5'd5);
		run_phase(MODE_UNUSED, 5'd16);
		run_phase(MODE_ID1, 5'd0);
		run_phase(MODE_NONE, 5'd0);
		// The closing phase runs at full rate on both sides.
		settle();
		bursts_on = 1'b0;
		run_phase(MODE_ID_PAIR, 5'd17);
		settle();

		$display("%0d seeds tested and %0d table loads over %0d filter settings,",
			tests_sent, loads_sent, settings_used);
		$display("%0d matching seeds checked field by field.", results_seen);
		if (mismatch_count == 0)
			$display("tb_mt_seed_id_derive_and_filter: clean");
		else
			$display("tb_mt_seed_id_derive_and_filter: errors");
		$finish;
	end

	// A time limit far beyond the whole run; reaching it ends the run with errors.
	initial begin
		#(8 * 400000);
		$display("tb_mt_seed_id_derive_and_filter: errors");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/mtsd_pkg.sv
src/mtsd_cell.sv
src/mtsd_filter.sv
src/mt_seed_id_derive_and_filter.sv
src/mtsd_checker.sv
bench/tb_mt_seed_id_derive_and_filter.sv
